/* hw/rtl/smda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_pkg: shared types and constants
// Fixed field widths, Q1.16 constants and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package smda_pkg;

	localparam int unsigned QW      = 17;
	localparam int unsigned DELTA_W = 16;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned SUM_W   = 23;
	localparam int unsigned SLOPE_W = 15;
	localparam int unsigned STEP_W  = 5;

	localparam logic [QW-1:0]    ONE_Q16   = 17'h10000;
	localparam logic [SUM_W-1:0] SUM_MAX   = 23'h7FFFFF;
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

	typedef struct packed {
		logic capture;
		logic slope;
		logic mag;
		logic sq;
		logic update;
		logic div_start;
		logic div_step;
		logic load_out;
	} smda_cmd_t;

	typedef struct packed {
		logic last;
		logic empty;
	} smda_status_t;

	// Saturate a Q1.16 input at one.
	function automatic logic [QW-1:0] clamp_one(input logic [QW-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

endpackage

/* hw/rtl/smda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_ctrl: sequencing controller
// Steps one item through the multiply, update and divide phases and owns
// the input stall and the output valid.
// ----------------------------------------------------------------------------
module smda_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  smda_pkg::smda_status_t status,
	output smda_pkg::smda_cmd_t    cmd
);
	import smda_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOPE,
		ST_MAG,
		ST_SQ,
		ST_UPDATE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.slope     = (state_q == ST_SLOPE);
		cmd.mag       = (state_q == ST_MAG);
		cmd.sq        = (state_q == ST_SQ);
		cmd.update    = (state_q == ST_UPDATE);
		cmd.div_start = (state_q == ST_PREP) && status.last && !status.empty;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.load_out  = (state_q == ST_DONE) && out_free;
	end

	// Advance the state, count divide steps, hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid as a result loads, drop it once transferred
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_SLOPE;
				end
				ST_SLOPE:  state_q <= ST_MAG;
				ST_MAG:    state_q <= ST_SQ;
				ST_SQ:     state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_PREP;
				ST_PREP: begin
					step_q <= '0;
					if (status.last && !status.empty)
						state_q <= ST_DIV;
					else
						state_q <= ST_DONE;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/smda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_datapath: delta, error accumulation, arg-max and mean divider
// One multiplier per phase, a running sum and maximum, and a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smda_datapath #(
	parameter int unsigned MAX_NEURONS = 64,
	parameter int unsigned CW          = 7
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [smda_pkg::QW-1:0]                neuron_output,
	input  logic [smda_pkg::QW-1:0]                expected_output,
	input  logic                                   last_of_vector,
	input  smda_pkg::smda_cmd_t                    cmd,
	output smda_pkg::smda_status_t                 status,
	output logic signed [smda_pkg::DELTA_W-1:0]    weight_delta,
	output logic [smda_pkg::QW-1:0]                mean_sq_error,
	output logic [smda_pkg::QW-1:0]                max_output,
	output logic [smda_pkg::IDX_W-1:0]             max_index,
	output logic                                   end_of_vector,
	output logic                                   overflow
);
	import smda_pkg::*;

	// Item registers
	logic [QW-1:0]      o_q;
	logic [QW-1:0]      err_q;
	logic               neg_q;
	logic               last_q;
	logic               drop_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [SLOPE_W-1:0] mag_q;
	logic [QW-1:0]      sq_q;

	// Vector state
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] sum_q;
	logic [QW-1:0]    best_q;
	logic [IDX_W-1:0] best_idx_q;

	// Divider
	logic [CW-1:0]    rem_q;
	logic [SUM_W-1:0] quo_q;

	// Output registers
	logic signed [DELTA_W-1:0] delta_q;
	logic [QW-1:0]             mean_q;
	logic [QW-1:0]             max_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      end_q;
	logic                      ovf_q;

	logic [QW-1:0]        o_in;
	logic [QW-1:0]        e_in;
	logic [QW-1:0]        one_minus_o;
	logic [2*QW-1:0]      slope_prod;
	logic [QW+SLOPE_W-1:0] mag_prod;
	logic [2*QW-1:0]      sq_prod;
	logic [SUM_W:0]       sum_next;
	logic [CW+IDX_W-1:0]  count_ext;
	logic [CW:0]          rem_sh;
	logic [CW:0]          rem_diff;
	logic [DELTA_W-1:0]   mag_ext;

	assign o_in        = clamp_one(neuron_output);
	assign e_in        = clamp_one(expected_output);
	assign one_minus_o = ONE_Q16 - o_q;
	assign slope_prod  = o_q * one_minus_o;
	assign mag_prod    = err_q * slope_q;
	assign sq_prod     = err_q * err_q;
	assign sum_next    = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
	assign count_ext   = (CW + IDX_W)'(count_q);
	assign rem_sh      = {rem_q, quo_q[SUM_W-1]};
	assign rem_diff    = rem_sh - {1'b0, count_q};
	assign mag_ext     = DELTA_W'(mag_q);

	assign status.last  = last_q;
	assign status.empty = (count_q == '0);

	// Capture the item and run the multiply phases
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			o_q    <= o_in;
			neg_q  <= (e_in < o_in);
			err_q  <= (e_in < o_in) ? (o_in - e_in) : (e_in - o_in);
			last_q <= last_of_vector;
			drop_q <= (count_q >= CW'(MAX_NEURONS));
		end
		if (cmd.slope)
			slope_q <= slope_prod[16 +: SLOPE_W];
		if (cmd.mag)
			mag_q <= mag_prod[16 +: SLOPE_W];
		if (cmd.sq)
			sq_q <= sq_prod[16 +: QW];
	end

	// Accumulate the vector state; clear it when a vector closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (cmd.update && !drop_q) begin
			sum_q   <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
			count_q <= count_q + 1'b1;
			if (count_q == '0 || o_q > best_q) begin
				best_q     <= o_q;
				best_idx_q <= count_ext[IDX_W-1:0];
			end
		end else if (cmd.load_out && last_q) begin
			count_q    <= '0;
			sum_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
		end
	end

	// Restoring division of the sum by the count, one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= sum_q;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, count_q}) begin
				rem_q <= rem_diff[CW-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CW-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (drop_q)
				delta_q <= '0;
			else if (neg_q)
				delta_q <= -$signed(mag_ext);
			else
				delta_q <= $signed(mag_ext);
			if (last_q && count_q != '0) begin
				mean_q <= quo_q[QW-1:0];
				max_q  <= best_q;
				idx_q  <= best_idx_q;
			end else begin
				mean_q <= '0;
				max_q  <= '0;
				idx_q  <= '0;
			end
			end_q <= last_q;
			ovf_q <= drop_q;
		end
	end

	assign weight_delta  = delta_q;
	assign mean_sq_error = mean_q;
	assign max_output    = max_q;
	assign max_index     = idx_q;
	assign end_of_vector = end_q;
	assign overflow      = ovf_q;

endmodule

/* hw/rtl/sigmoid_output_delta_mse_argmax_unit.sv */
`timescale 1ns / 1ps
// An accepted item steps through the slope, magnitude, square, update and prep
// states, and also through the bit-serial mean divider when it closes a non-empty vector.
// A new item is not taken until the current one loads its result; the next item is
// taken while a finished result still waits on the output register.
// Reset (arst_n low): controller idles, output valid drops, running sum,
// count and maximum clear to zero.
// ----------------------------------------------------------------------------
// sigmoid_output_delta_mse_argmax_unit: output-layer delta and summary
// Gives the sigmoid back-propagation delta per neuron and, at the end of a
// vector, the mean squared error and the arg-max of the outputs.
// ----------------------------------------------------------------------------
module sigmoid_output_delta_mse_argmax_unit #(
	parameter int unsigned MAX_NEURONS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [smda_pkg::QW-1:0]             neuron_output,
	input  logic [smda_pkg::QW-1:0]             expected_output,
	input  logic                                last_of_vector,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [smda_pkg::DELTA_W-1:0] weight_delta,
	output logic [smda_pkg::QW-1:0]             mean_sq_error,
	output logic [smda_pkg::QW-1:0]             max_output,
	output logic [smda_pkg::IDX_W-1:0]          max_index,
	output logic                                end_of_vector,
	output logic                                overflow
);
	import smda_pkg::*;

	localparam int unsigned CW = $clog2(MAX_NEURONS + 1);

	smda_cmd_t    cmd;
	smda_status_t status;

	// Sequence the item phases
	smda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and vector state
	smda_datapath #(
		.MAX_NEURONS (MAX_NEURONS),
		.CW          (CW)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.neuron_output   (neuron_output),
		.expected_output (expected_output),
		.last_of_vector  (last_of_vector),
		.cmd             (cmd),
		.status          (status),
		.weight_delta    (weight_delta),
		.mean_sq_error   (mean_sq_error),
		.max_output      (max_output),
		.max_index       (max_index),
		.end_of_vector   (end_of_vector),
		.overflow        (overflow)
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sigmoid output-layer delta, MSE and arg-max unit
// Drives neurons through a valid/stall channel: a short table of edge cases,
// then random vectors of assorted lengths, some past the neuron limit. A
// behavioural predictor gives the expected delta and vector summary, and each
// output transfer is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

	import smda_pkg::*;

	localparam int unsigned NEURON_LIMIT = 64;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS  = 150;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic [QW-1:0]             mse;
		logic [QW-1:0]             peak;
		logic [IDX_W-1:0]          peak_idx;
		logic                      eov;
		logic                      ovf;
	} layer_result_t;

	typedef struct packed {
		logic [QW-1:0] o;
		logic [QW-1:0] e;
		logic          last;
		logic          known;
		layer_result_t res;
	} stim_row_t;

	// Edge cases; results are typed in where they follow directly from the maths
	localparam stim_row_t DIRECTED [16] = '{
		'{17'd0,      17'd0,      1'b1, 1'b1, '{16'sd0,     17'd0,     17'd0,     6'd0, 1'b1, 1'b0}},
		'{17'd65536,  17'd0,      1'b1, 1'b1, '{16'sd0,     17'd65536, 17'd65536, 6'd0, 1'b1, 1'b0}},
		'{17'd0,      17'd65536,  1'b1, 1'b1, '{16'sd0,     17'd65536, 17'd0,     6'd0, 1'b1, 1'b0}},
		'{17'd131071, 17'd131071, 1'b1, 1'b1, '{16'sd0,     17'd0,     17'd65536, 6'd0, 1'b1, 1'b0}},
		'{17'd32768,  17'd65536,  1'b1, 1'b1, '{16'sd8192,  17'd16384, 17'd32768, 6'd0, 1'b1, 1'b0}},
		'{17'd32768,  17'd0,      1'b1, 1'b1, '{-16'sd8192, 17'd16384, 17'd32768, 6'd0, 1'b1, 1'b0}},
		'{17'd0,      17'd100,    1'b0, 1'b1, '{16'sd0,     17'd0,     17'd0,     6'd0, 1'b0, 1'b0}},
		'{17'd0,      17'd200,    1'b1, 1'b1, '{16'sd0,     17'd0,     17'd0,     6'd0, 1'b1, 1'b0}},
		'{17'd65535,  17'd1,      1'b0, 1'b0, '0},
		'{17'd40000,  17'd30000,  1'b0, 1'b0, '0},
		'{17'd50000,  17'd65536,  1'b0, 1'b0, '0},
		'{17'd50000,  17'd0,      1'b0, 1'b0, '0},
		'{17'd10000,  17'd131071, 1'b0, 1'b0, '0},
		'{17'd50000,  17'd50000,  1'b1, 1'b0, '0},
		'{17'd0,      17'd131071, 1'b0, 1'b0, '0},
		'{17'd65536,  17'd65535,  1'b1, 1'b0, '0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [QW-1:0]             neuron_output = '0;
	logic [QW-1:0]             expected_output = '0;
	logic                      last_of_vector = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b1;
	logic signed [DELTA_W-1:0] weight_delta;
	logic [QW-1:0]             mean_sq_error;
	logic [QW-1:0]             max_output;
	logic [IDX_W-1:0]          max_index;
	logic                      end_of_vector;
	logic                      overflow;

	// Predictor state for the vector in progress
	int unsigned      layer_count = 0;
	logic [SUM_W-1:0] sq_err_sum = '0;
	logic [QW-1:0]    best_out = '0;
	logic [IDX_W-1:0] best_idx = '0;

	layer_result_t    pending_results [$];
	layer_result_t    oldest;
	int unsigned      send_idle_pct = 0;
	int unsigned      stall_pct = 0;
	int unsigned      quiet_cycles = 0;
	bit               failed = 1'b0;

	sigmoid_output_delta_mse_argmax_unit #(
		.MAX_NEURONS(NEURON_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.neuron_output(neuron_output),
		.expected_output(expected_output),
		.last_of_vector(last_of_vector),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.weight_delta(weight_delta),
		.mean_sq_error(mean_sq_error),
		.max_output(max_output),
		.max_index(max_index),
		.end_of_vector(end_of_vector),
		.overflow(overflow)
	);

	always #6 clk = ~clk;

	// Delta for one neuron, plus the vector summary when it closes the vector
	function automatic layer_result_t neuron_delta_and_summary(input logic [QW-1:0] o_in,
			input logic [QW-1:0] e_in, input logic last);
		layer_result_t    r;
		bit [63:0]        o;
		bit [63:0]        e;
		bit [63:0]        slope;
		bit [63:0]        err;
		bit [63:0]        mag;
		bit [63:0]        sq;
		bit [63:0]        total;
		bit               neg;
		bit [DELTA_W-1:0] d;
		r = '0;
		o = (o_in > ONE_Q16) ? 64'(ONE_Q16) : 64'(o_in);
		e = (e_in > ONE_Q16) ? 64'(ONE_Q16) : 64'(e_in);
		if (layer_count >= NEURON_LIMIT) begin
			// drop: no state change
			r.ovf = 1'b1;
		end else begin
			slope = (o * (64'(ONE_Q16) - o)) >> 16;
			neg   = e < o;
			err   = neg ? o - e : e - o;
			mag   = (err * slope) >> 16;
			sq    = (err * err) >> 16;
			d = mag[DELTA_W-1:0];
			if (neg) begin
				d = -d;
			end
			r.delta = d;
			total = 64'(sq_err_sum) + sq;
			sq_err_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
			if (layer_count == 0 || o[QW-1:0] > best_out) begin
				best_out = o[QW-1:0];
				best_idx = layer_count[IDX_W-1:0];
			end
			layer_count++;
		end
		r.eov = last;
		if (last) begin
			if (layer_count != 0) begin
				total = 64'(sq_err_sum) / 64'(layer_count);
				r.mse = total[QW-1:0];
				r.peak = best_out;
				r.peak_idx = best_idx;
			end
			layer_count = 0;
			sq_err_sum = '0;
			best_out = '0;
			best_idx = '0;
		end
		return r;
	endfunction

	// Q1.16 value biased towards zero, one and values above one
	function automatic logic [QW-1:0] random_q16();
		case ($urandom_range(9))
			0: return '0;
			1: return ONE_Q16;
			2: return QW'($urandom_range(2 ** QW - 1));
			default: return QW'($urandom_range(int'(ONE_Q16)));
		endcase
	endfunction

	// Offer one neuron, with random gaps carrying junk payload, until transferred
	task automatic send_neuron(input logic [QW-1:0] o, input logic [QW-1:0] e,
			input logic last, input bit known, input layer_result_t typed);
		layer_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			neuron_output <= QW'($urandom);
			expected_output <= QW'($urandom);
			last_of_vector <= 1'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		neuron_output <= o;
		expected_output <= e;
		last_of_vector <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predicted = neuron_delta_and_summary(o, e, last);
		pending_results.push_back(known ? typed : predicted);
	endtask

	// Random vectors; the first one always runs past the neuron limit
	task automatic run_random_vectors(input int unsigned quota);
		int unsigned   done;
		int unsigned   len;
		logic [QW-1:0] o;
		logic [QW-1:0] prev_o;
		done = 0;
		len = $urandom_range(NEURON_LIMIT + 6, NEURON_LIMIT + 1);
		while (done < quota) begin
			prev_o = random_q16();
			for (int unsigned k = 0; k < len; k++) begin
				// repeat an earlier output now and then to exercise ties
				o = ($urandom_range(5) == 0) ? prev_o : random_q16();
				send_neuron(o, random_q16(), k == len - 1, 1'b0, '0);
				prev_o = o;
			end
			done += len;
			case ($urandom_range(19))
				0: len = $urandom_range(NEURON_LIMIT + 6, NEURON_LIMIT + 1);
				1, 2: len = $urandom_range(NEURON_LIMIT, NEURON_LIMIT - 4);
				default: len = $urandom_range(10, 1);
			endcase
		end
	endtask

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Check each output transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expectation pending");
				failed = 1'b1;
			end else begin
				oldest = pending_results.pop_front();
				compare_field("weight_delta", longint'(oldest.delta), longint'(weight_delta));
				compare_field("mean_sq_error", longint'(oldest.mse), longint'(mean_sq_error));
				compare_field("max_output", longint'(oldest.peak), longint'(max_output));
				compare_field("max_index", longint'(oldest.peak_idx), longint'(max_index));
				compare_field("end_of_vector", longint'(oldest.eov), longint'(end_of_vector));
				compare_field("overflow", longint'(oldest.ovf), longint'(overflow));
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("** sigmoid_output_delta_mse_argmax_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 28;
		stall_pct = 86;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Walk the table of edge cases
		foreach (DIRECTED[i]) begin
			send_neuron(DIRECTED[i].o, DIRECTED[i].e, DIRECTED[i].last, DIRECTED[i].known,
				DIRECTED[i].res);
		end

		// Random vectors under three idling profiles
		run_random_vectors(PHASE_ITEMS);
		send_idle_pct = 86;
		stall_pct = 28;
		run_random_vectors(PHASE_ITEMS);
		send_idle_pct = 0;
		stall_pct = 0;
		run_random_vectors(PHASE_ITEMS);
		@(negedge clk) in_valid <= 1'b0;

		// Drain, then allow time for any stray result to show up
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("** sigmoid_output_delta_mse_argmax_unit: PASSED **");
		end else begin
			$display("** sigmoid_output_delta_mse_argmax_unit: FAILED **");
		end
		$finish;
	end

endmodule
